@@ design/escaped_frame_receiver_crc_check_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame receiver
// Clocked, reset-qualified property checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH

// Property checked at every rising edge of clk, off while arst_n is low.
`define EFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same, for an implication written as antecedent and consequent.
`define EFR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/efr_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Framing codes, sizes, result type and the CRC-16/XMODEM byte update.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int unsigned BUFFER_BYTES = 256;
	localparam int unsigned FILL_W       = $clog2(BUFFER_BYTES + 1);

	localparam logic [7:0] START_BYTE   = 8'hF1;
	localparam logic [7:0] ESCAPE_BYTE  = 8'hF2;
	localparam logic [7:0] START_ALIAS  = 8'h0E;
	localparam logic [7:0] ESCAPE_ALIAS = 8'h0D;

	// header is positions 0..4, CRC covers 1..size+4
	localparam logic [FILL_W-1:0] POS_HEADER = FILL_W'(1);
	localparam logic [FILL_W-1:0] POS_KIND   = FILL_W'(2);
	localparam logic [FILL_W-1:0] POS_NUMBER = FILL_W'(3);
	localparam logic [FILL_W-1:0] POS_LENGTH = FILL_W'(4);
	localparam logic [FILL_W-1:0] POS_DATA   = FILL_W'(5);

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic       has_result;
		logic [7:0] stored_byte;
		logic [7:0] byte_position;
		logic       is_payload;
		logic       frame_done;
		logic       crc_ok;
		logic [7:0] header_field;
		logic [7:0] message_kind;
		logic [7:0] message_number;
		logic [7:0] payload_length;
	} result_t;

	// MSB-first CRC-16, one byte per call
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ design/efr_frame_core.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver core
// Frame state (fill count, escape flag, running CRC, header fields) and the
// per-byte unescape, position and CRC logic.
// ----------------------------------------------------------------------------
module efr_frame_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	input  logic [15:0]           crc_seed_q,
	output efr_pkg::result_t      res
);

	logic [efr_pkg::FILL_W-1:0] fill_q;
	logic                       escape_q;
	logic [15:0]                crc_q;
	logic [7:0]                 header_q, kind_q, number_q, length_q, crc_hi_q;

	logic                       is_esc, restart, in_crc, payload, done, at_crc_hi;
	logic [7:0]                 b;
	logic [efr_pkg::FILL_W-1:0] pos;
	logic [15:0]                crc_base, crc_next;
	logic [efr_pkg::FILL_W:0]   pos_x, len_x;

	always_comb begin
		is_esc  = (byte_in == efr_pkg::ESCAPE_BYTE);
		restart = (byte_in == efr_pkg::START_BYTE) ||
			(fill_q >= efr_pkg::FILL_W'(efr_pkg::BUFFER_BYTES));

		// a restart drops any pending escape
		b = byte_in;
		if (escape_q && !restart) begin
			if (byte_in == efr_pkg::START_ALIAS)
				b = efr_pkg::START_BYTE;
			else if (byte_in == efr_pkg::ESCAPE_ALIAS)
				b = efr_pkg::ESCAPE_BYTE;
		end

		pos      = restart ? '0 : fill_q;
		crc_base = restart ? crc_seed_q : crc_q;

		pos_x = {1'b0, pos};
		len_x = (efr_pkg::FILL_W + 1)'(length_q);

		payload   = (pos >= efr_pkg::POS_DATA) && (pos_x <= len_x + 4);
		at_crc_hi = (pos >= efr_pkg::POS_DATA) && (pos_x == len_x + 5);
		done      = (pos >= efr_pkg::POS_DATA) && (pos_x == len_x + 6);
		in_crc    = payload || ((pos >= efr_pkg::POS_HEADER) && (pos < efr_pkg::POS_DATA));
		crc_next  = efr_pkg::crc_byte(crc_base, b);

		res.has_result     = !is_esc;
		res.stored_byte    = b;
		res.byte_position  = pos[7:0];
		res.is_payload     = payload;
		res.frame_done     = done;
		res.crc_ok         = done && ({crc_hi_q, b} == crc_base);
		res.header_field   = done ? header_q : 8'h00;
		res.message_kind   = done ? kind_q   : 8'h00;
		res.message_number = done ? number_q : 8'h00;
		res.payload_length = done ? length_q : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			escape_q <= 1'b0;
			crc_q    <= '0;
			header_q <= '0;
			kind_q   <= '0;
			number_q <= '0;
			length_q <= '0;
			crc_hi_q <= '0;
		end else if (step) begin
			if (is_esc) begin
				escape_q <= 1'b1;
			end else begin
				escape_q <= 1'b0;
				fill_q   <= done ? '0 : pos + 1'b1;
				if (done)
					crc_q <= crc_seed_q;
				else if (in_crc)
					crc_q <= crc_next;
				else
					crc_q <= crc_base;
				if (pos == efr_pkg::POS_HEADER) header_q <= b;
				if (pos == efr_pkg::POS_KIND)   kind_q   <= b;
				if (pos == efr_pkg::POS_NUMBER) number_q <= b;
				if (pos == efr_pkg::POS_LENGTH) length_q <= b;
				if (at_crc_hi)                  crc_hi_q <= b;
			end
		end
	end

endmodule

@@ design/escaped_frame_receiver_crc_check.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver with CRC-16/XMODEM check
// Rebuilds byte-stuffed frames from a link byte stream and checks their CRC.
//
// One link byte is taken per request on the input channel, one byte per clock
// sustained while the output register is free or being drained. A byte is
// registered on acceptance, then unescaped and scored against the frame state,
// and its result is loaded into the output register once that register is
// free or being drained. The rate is set by the frame state update (position,
// escape flag and the unrolled 8-bit CRC step). While a result
// waits in the output register, stage 1 takes one more byte and the input
// then stalls until the result is taken. An escape byte (0xF2) gives no
// result; every other byte gives one, tagged with its frame position. A
// start byte (0xF1) or a full buffer restarts the frame at position 0. The
// byte that completes a frame (position size+6) carries frame_done, crc_ok
// and the four header fields; these are zero on all other results. A write
// of crc_seed takes effect at the next frame start and is only to be made
// while the block is idle.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc_check (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] crc_seed,

	// link byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  link_byte,

	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  stored_byte,
	output logic [7:0]  byte_position,
	output logic        is_payload,
	output logic        frame_done,
	output logic        crc_ok,
	output logic [7:0]  header_field,
	output logic [7:0]  message_kind,
	output logic [7:0]  message_number,
	output logic [7:0]  payload_length
);

	logic [15:0]      crc_seed_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             out_valid_q;
	efr_pkg::result_t res;
	efr_pkg::result_t out_q;

	// seed register: always writable, used at each frame start
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			crc_seed_q <= '0;
		else if (cfg_valid && cfg_ready)
			crc_seed_q <= crc_seed;
	end

	// stage 1 moves on once the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= link_byte;
	end

	efr_frame_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_in    (byte_s1),
		.crc_seed_q (crc_seed_q),
		.res        (res)
	);

	// output register: loaded only for bytes that produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && res.has_result)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result)
			out_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign stored_byte    = out_q.stored_byte;
	assign byte_position  = out_q.byte_position;
	assign is_payload     = out_q.is_payload;
	assign frame_done     = out_q.frame_done;
	assign crc_ok         = out_q.crc_ok;
	assign header_field   = out_q.header_field;
	assign message_kind   = out_q.message_kind;
	assign message_number = out_q.message_number;
	assign payload_length = out_q.payload_length;

endmodule

@@ design/efr_checker.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver port checker
// Checks result framing rules seen on the top-level ports; bound to the top.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_crc_check_macros.svh"

module efr_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] stored_byte,
	input  logic [7:0] byte_position,
	input  logic       is_payload,
	input  logic       frame_done,
	input  logic       crc_ok,
	input  logic [7:0] header_field,
	input  logic [7:0] message_kind,
	input  logic [7:0] message_number,
	input  logic [7:0] payload_length
);

	// a stalled result holds
	`EFR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(stored_byte) && $stable(byte_position)), "result changed while stalled")

	// the completing byte is the second CRC byte, outside the data
	`EFR_ASSERT_IMPL(a_done_pos, out_valid && frame_done, !is_payload && (byte_position == payload_length + 8'd6), "frame end at wrong position")

	// frame fields are zero except on the completing byte
	`EFR_ASSERT_IMPL(a_fields_zero, out_valid && !frame_done, !crc_ok && (header_field == 8'h00) && (message_kind == 8'h00) && (message_number == 8'h00) && (payload_length == 8'h00), "frame fields set without frame end")

	// data bytes never fall inside the header
	`EFR_ASSERT_IMPL(a_payload_pos, out_valid && is_payload, byte_position >= 8'd5, "data byte inside header")

endmodule

bind escaped_frame_receiver_crc_check efr_checker u_efr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.stored_byte    (stored_byte),
	.byte_position  (byte_position),
	.is_payload     (is_payload),
	.frame_done     (frame_done),
	.crc_ok         (crc_ok),
	.header_field   (header_field),
	.message_kind   (message_kind),
	.message_number (message_number),
	.payload_length (payload_length)
);
